@@ design/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the transaction structs, byte-class masks and surrogate constants.
// No dependencies.
package u8u16_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        error;
        logic        last;
    } t_out_item;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_2B   = 2'd1;
    localparam logic [1:0] SEQ_3B   = 2'd2;
    localparam logic [1:0] SEQ_4B   = 2'd3;

    localparam logic [1:0] POS_SECOND = 2'd0;
    localparam logic [1:0] POS_THIRD  = 2'd1;

    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_VALUE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'h60;
    localparam logic [7:0] LEAD2_VALUE = 8'h40;
    localparam logic [7:0] LEAD3_MASK  = 8'h70;
    localparam logic [7:0] LEAD3_VALUE = 8'h60;
    localparam logic [7:0] LEAD4_MASK  = 8'h78;
    localparam logic [7:0] LEAD4_VALUE = 8'h70;
    localparam logic [3:0] SURR_LEAD_LO = 4'hD;

    localparam logic [15:0] HIGH_SURR   = 16'hD800;
    localparam logic [15:0] LOW_SURR    = 16'hDC00;
    localparam logic [15:0] PLANE_SHIFT = 16'h0040;

endpackage

@@ design/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: decoder state and result queue.
// Depends on u8u16_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one UTF-8 byte
//   per transaction, with end_of_string set on the final byte of a string.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries UTF-16 code
//   units; a 4-byte sequence gives a high then a low surrogate. An invalid
//   string gives a single result with error and last set and code_unit zero,
//   which tells the receiver to discard the units already sent for it.
//   A result is written to the queue when the byte that completes it is taken.
//   Throughput: one byte per cycle while the queue has room; one result per
//   cycle leaves while i_out_ready is high, a surrogate pair as two results.
//   The four-entry queue sets the rate: it takes a byte when two entries are free.
//   Reset clears the decoder state and empties the queue.
//   When the receiver stalls, the queue fills and o_in_ready falls once fewer
//   than two entries are free; the head result holds until taken.
module utf8_to_utf16_transcoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  u8u16_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output u8u16_pkg::t_out_item o_out_data
);
    import u8u16_pkg::*;

    logic [7:0]       r_lead, n_lead;
    logic [7:0]       r_second, n_second;
    logic [7:0]       r_third, n_third;
    logic [1:0]       r_pending, n_pending;
    logic [1:0]       r_seq_len, n_seq_len;
    logic             r_failed, n_failed;

    t_out_item        r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic             in_take, out_take;
    logic [1:0]       n_units;
    t_out_item        unit0, unit1;
    logic [7:0]       b;
    logic [1:0]       pos;
    logic [10:0]      upper;
    logic [15:0]      upper_adj;
    logic [PTR_W-1:0] wr_ptr_next;

    assign o_in_ready  = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign in_take     = i_in_valid && o_in_ready;
    assign out_take    = o_out_valid && i_out_ready;

    assign b           = i_in_data.in_byte;
    assign pos         = r_seq_len - r_pending;
    assign upper       = {r_lead[2:0], r_second[5:0], r_third[5:4]};
    assign upper_adj   = {5'b0, upper} - PLANE_SHIFT;
    assign wr_ptr_next = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_lead    = r_lead;
        n_second  = r_second;
        n_third   = r_third;
        n_pending = r_pending;
        n_seq_len = r_seq_len;
        n_failed  = r_failed;
        n_units   = 2'd0;
        unit0     = '0;
        unit1     = '0;

        if (!r_failed) begin
            if (r_pending == 2'd0) begin
                priority if (b < CONT_VALUE) begin
                    unit0.code_unit = {8'h00, b};
                    n_units         = 2'd1;
                end else if ((b & LEAD2_MASK) == LEAD2_VALUE) begin
                    n_lead    = b;
                    n_seq_len = SEQ_2B;
                    n_pending = SEQ_2B;
                end else if ((b & LEAD3_MASK) == LEAD3_VALUE) begin
                    n_lead    = b;
                    n_seq_len = SEQ_3B;
                    n_pending = SEQ_3B;
                end else if ((b & LEAD4_MASK) == LEAD4_VALUE) begin
                    n_lead    = b;
                    n_seq_len = SEQ_4B;
                    n_pending = SEQ_4B;
                end else begin
                    n_failed = 1'b1;
                end
            end else if ((b & CONT_MASK) != CONT_VALUE) begin
                n_failed = 1'b1;
            end else begin
                if (pos == POS_SECOND) begin
                    n_second = b;
                end else if (pos == POS_THIRD) begin
                    n_third = b;
                end
                if (r_seq_len == SEQ_3B && pos == POS_SECOND &&
                    r_lead[3:0] == SURR_LEAD_LO && b[5]) begin
                    n_failed = 1'b1;
                end else begin
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        unique case (r_seq_len)
                            SEQ_2B: begin
                                unit0.code_unit = {5'b0, r_lead[4:0], b[5:0]};
                                n_units         = 2'd1;
                            end
                            SEQ_3B: begin
                                unit0.code_unit = {r_lead[3:0], r_second[5:0], b[5:0]};
                                n_units         = 2'd1;
                            end
                            SEQ_4B: begin
                                unit0.code_unit = HIGH_SURR | upper_adj;
                                unit1.code_unit = LOW_SURR | {6'b0, r_third[3:0], b[5:0]};
                                n_units         = 2'd2;
                            end
                            default: begin
                                n_units = 2'd0;
                            end
                        endcase
                        n_seq_len = SEQ_NONE;
                    end
                end
            end
        end

        if (i_in_data.end_of_string) begin
            if (n_failed || n_pending != 2'd0) begin
                unit0   = '{code_unit: 16'h0000, error: 1'b1, last: 1'b1};
                n_units = 2'd1;
            end else if (n_units == 2'd1) begin
                unit0.last = 1'b1;
            end else if (n_units == 2'd2) begin
                unit1.last = 1'b1;
            end
            n_lead    = '0;
            n_second  = '0;
            n_third   = '0;
            n_pending = '0;
            n_seq_len = SEQ_NONE;
            n_failed  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_second  <= '0;
            r_third   <= '0;
            r_pending <= '0;
            r_seq_len <= SEQ_NONE;
            r_failed  <= 1'b0;
        end else if (in_take) begin
            r_lead    <= n_lead;
            r_second  <= n_second;
            r_third   <= n_third;
            r_pending <= n_pending;
            r_seq_len <= n_seq_len;
            r_failed  <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && n_units != 2'd0) begin
            r_fifo[r_wr_ptr] <= unit0;
        end
        if (in_take && n_units == 2'd2) begin
            r_fifo[wr_ptr_next] <= unit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + (in_take ? PTR_W'(n_units) : PTR_W'(0));
            r_rd_ptr <= r_rd_ptr + (out_take ? PTR_W'(1) : PTR_W'(0));
            r_count  <= r_count + (in_take ? CNT_W'(n_units) : CNT_W'(0))
                        - (out_take ? CNT_W'(1) : CNT_W'(0));
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_pending_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd0 |-> r_seq_len != SEQ_NONE && r_pending <= r_seq_len)
        else $error("pending count outside open sequence");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in_data.end_of_string |=> r_pending == 2'd0 && !r_failed)
        else $error("decoder state not cleared at end of string");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> o_out_data.last && o_out_data.code_unit == 16'h0000)
        else $error("error result without last or with nonzero unit");

endmodule

@@ test/utf16_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the UTF-8 to UTF-16 transcoder: decodes each accepted byte into
// the code units it should give and compares them with the output transactions.
// Depends on u8u16_pkg.
module utf16_unit_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  u8u16_pkg::t_in_item  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  u8u16_pkg::t_out_item i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import u8u16_pkg::*;

    logic [7:0] lead_b;
    logic [7:0] second_b;
    logic [7:0] third_b;
    logic [1:0] cont_left;
    logic [1:0] cont_total;
    logic       string_bad;

    t_out_item expected_units[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic t_out_item make_unit(input logic [15:0] value);
        t_out_item unit;
        unit.code_unit = value;
        unit.error     = 1'b0;
        unit.last      = 1'b0;
        return unit;
    endfunction

    task automatic clear_decoder();
        lead_b     = 8'h00;
        second_b   = 8'h00;
        third_b    = 8'h00;
        cont_left  = 2'd0;
        cont_total = SEQ_NONE;
        string_bad = 1'b0;
    endtask

    task automatic decode_utf8_byte(input t_in_item item);
        logic [7:0]  b;
        logic [1:0]  pos;
        logic [10:0] upper;
        t_out_item   units[$];
        t_out_item   err_unit;
        b = item.in_byte;
        if (!string_bad) begin
            if (cont_left == 2'd0) begin
                if (b[7] == 1'b0) begin
                    units.push_back(make_unit({8'h00, b}));
                end else if ((b & LEAD2_MASK) == LEAD2_VALUE) begin
                    lead_b     = b;
                    cont_total = SEQ_2B;
                    cont_left  = SEQ_2B;
                end else if ((b & LEAD3_MASK) == LEAD3_VALUE) begin
                    lead_b     = b;
                    cont_total = SEQ_3B;
                    cont_left  = SEQ_3B;
                end else if ((b & LEAD4_MASK) == LEAD4_VALUE) begin
                    lead_b     = b;
                    cont_total = SEQ_4B;
                    cont_left  = SEQ_4B;
                end else begin
                    string_bad = 1'b1;
                end
            end else if ((b & CONT_MASK) != CONT_VALUE) begin
                string_bad = 1'b1;
            end else begin
                pos = cont_total - cont_left;
                if (pos == POS_SECOND) begin
                    second_b = b;
                end else if (pos == POS_THIRD) begin
                    third_b = b;
                end
                // reject ED A0-BF: an encoded surrogate
                if (cont_total == SEQ_3B && pos == POS_SECOND &&
                    lead_b[3:0] == SURR_LEAD_LO && b[5]) begin
                    string_bad = 1'b1;
                end else begin
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        case (cont_total)
                            SEQ_2B: begin
                                units.push_back(make_unit({5'b0, lead_b[4:0], b[5:0]}));
                            end
                            SEQ_3B: begin
                                units.push_back(make_unit({lead_b[3:0], second_b[5:0],
                                                           b[5:0]}));
                            end
                            default: begin
                                upper = {lead_b[2:0], second_b[5:0], third_b[5:4]};
                                units.push_back(make_unit(HIGH_SURR |
                                                          ({5'b0, upper} - PLANE_SHIFT)));
                                units.push_back(make_unit(LOW_SURR |
                                                          {6'b0, third_b[3:0], b[5:0]}));
                            end
                        endcase
                        cont_total = SEQ_NONE;
                    end
                end
            end
        end

        if (item.end_of_string) begin
            if (!string_bad && cont_left != 2'd0) begin
                string_bad = 1'b1;
            end
            if (string_bad) begin
                units.delete();
                err_unit.code_unit = 16'h0000;
                err_unit.error     = 1'b1;
                err_unit.last      = 1'b1;
                units.push_back(err_unit);
            end else if (units.size() > 0) begin
                units[units.size() - 1].last = 1'b1;
            end
            clear_decoder();
        end

        foreach (units[i]) begin
            expected_units.push_back(units[i]);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            clear_decoder();
            expected_units.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected output transaction: code_unit %h error %b last %b",
                           i_out_data.code_unit, i_out_data.error, i_out_data.last);
                    fail_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (i_out_data.code_unit !== want.code_unit) begin
                        $error("code_unit expected %h actual %h",
                               want.code_unit, i_out_data.code_unit);
                        fail_count++;
                    end
                    if (i_out_data.error !== want.error) begin
                        $error("error expected %b actual %b", want.error, i_out_data.error);
                        fail_count++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last expected %b actual %b", want.last, i_out_data.last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_utf8_byte(i_in_data);
            end
        end
        o_pending <= expected_units.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for utf8_to_utf16_transcoder: clock, reset, byte and ready stimulus,
// watchdog and verdict. Depends on u8u16_pkg, the transcoder and utf16_unit_checker.
module tb_top;
    import u8u16_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending_units;
    int sender_idle_pct   = 37;
    int receiver_idle_pct = 87;
    bit long_hold_req     = 1'b0;
    int stall_cycles      = 0;

    logic [7:0] utf8_bytes[$];

    // {end_of_string, byte}: extremes, every sequence length, wrapped surrogate,
    // stray and F8-FF leads, bad continuation, encoded surrogate, truncation
    logic [8:0] directed_items[$] = '{
        9'h000, 9'h07F, 9'h0DF, 9'h1BF,
        9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h080, 9'h141,
        9'h1FF,
        9'h0C2, 9'h141,
        9'h0ED, 9'h0A0, 9'h180,
        9'h0E2, 9'h182
    };

    always #2 clk = ~clk;

    utf8_to_utf16_transcoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    utf16_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_units)
    );

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic last_byte);
        t_in_item item;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.in_byte       = value;
        item.end_of_string = last_byte;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic build_string();
        int         chars;
        int         pick;
        int         pos;
        logic [7:0] lead;
        utf8_bytes.delete();
        chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        repeat (chars) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                utf8_bytes.push_back(8'($urandom_range(0, 127)));
            end else if (pick < 55) begin
                utf8_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                utf8_bytes.push_back(cont_byte());
            end else if (pick < 80) begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                utf8_bytes.push_back(lead);
                utf8_bytes.push_back((lead == 8'hED) ? (8'h80 | 8'($urandom_range(0, 31)))
                                                     : cont_byte());
                utf8_bytes.push_back(cont_byte());
            end else begin
                utf8_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                utf8_bytes.push_back(cont_byte());
                utf8_bytes.push_back(cont_byte());
                utf8_bytes.push_back(cont_byte());
            end
        end
        if ($urandom_range(0, 99) < 20) begin
            pos = $urandom_range(0, utf8_bytes.size());
            case ($urandom_range(0, 3))
                0: utf8_bytes.insert(pos, 8'($urandom_range(0, 255)));
                1: begin
                    if (utf8_bytes.size() > 1) begin
                        void'(utf8_bytes.pop_back());
                    end
                end
                2: begin
                    utf8_bytes.insert(pos, cont_byte());
                    utf8_bytes.insert(pos, 8'hA0 | 8'($urandom_range(0, 31)));
                    utf8_bytes.insert(pos, 8'hED);
                end
                default: begin
                    utf8_bytes.insert(pos, $urandom_range(0, 1) ? cont_byte()
                                                                : (8'hF8 | 8'($urandom_range(0, 7))));
                end
            endcase
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_units != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        int phase;
        int sent;
        wait (rst_n);
        @(posedge clk);

        foreach (directed_items[i]) begin
            send_byte(directed_items[i][7:0], directed_items[i][8]);
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 37;
                    receiver_idle_pct = 87;
                end
                1: begin
                    sender_idle_pct   = 87;
                    receiver_idle_pct = 37;
                    long_hold_req     = 1'b1;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    long_hold_req     = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                build_string();
                foreach (utf8_bytes[i]) begin
                    send_byte(utf8_bytes[i], i == utf8_bytes.size() - 1);
                end
                sent += utf8_bytes.size();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
